@@ rtl/pec_pkg.sv @@
// pec_pkg: shared types, constants and arithmetic helpers of the pixel effect chain.
// Used by pixel_effect_chain_unit and by the tb bench; depends on nothing else.
package pec_pkg;

  localparam int MaxSlots     = 4;
  localparam int DefaultSlots = MaxSlots;
  localparam int EffectW      = 3;
  localparam int FactorW      = 16;
  localparam int CfgDataW     = FactorW;
  localparam int CfgIdxW      = $clog2(2 * MaxSlots);
  localparam int AccW         = 27;

  localparam logic signed [FactorW-1:0] FactorReset = 16'sd256;

  // luma weights, Q0.8
  localparam logic [15:0] LumaKr = 16'd77;
  localparam logic [15:0] LumaKg = 16'd150;
  localparam logic [15:0] LumaKb = 16'd29;

  // sepia matrix, Q0.16
  localparam logic [15:0] SepRr = 16'd25756;
  localparam logic [15:0] SepRg = 16'd50397;
  localparam logic [15:0] SepRb = 16'd12386;
  localparam logic [15:0] SepGr = 16'd22872;
  localparam logic [15:0] SepGg = 16'd44958;
  localparam logic [15:0] SepGb = 16'd11010;
  localparam logic [15:0] SepBr = 16'd17826;
  localparam logic [15:0] SepBg = 16'd34996;
  localparam logic [15:0] SepBb = 16'd8585;

  localparam logic signed [AccW-1:0] ContrastBias = 27'sd32768;

  typedef enum logic [EffectW-1:0] {
    FxNone     = 3'd0,
    FxBright   = 3'd1,
    FxContrast = 3'd2,
    FxSat      = 3'd3,
    FxGray     = 3'd4,
    FxSepia    = 3'd5,
    FxInvert   = 3'd6
  } effect_e;

  typedef logic signed [AccW-1:0] acc_t;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } rgb_t;

  function automatic logic [7:0] clamp8(acc_t v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > 27'sd255) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // divide by 256, rounding toward zero
  function automatic acc_t div256_tz(acc_t v);
    acc_t res;
    if (v < 0) begin
      res = (v + 27'sd255) >>> 8;
    end else begin
      res = v >>> 8;
    end
    return res;
  endfunction

  function automatic logic [7:0] luma_of(rgb_t p);
    logic [15:0] sum;
    sum = 16'(p.r) * LumaKr + 16'(p.g) * LumaKg + 16'(p.b) * LumaKb;
    return sum[15:8];
  endfunction

  function automatic logic [7:0] sepia_ch(rgb_t p, logic [15:0] kr, logic [15:0] kg,
                                          logic [15:0] kb);
    logic [24:0] sum;
    logic [8:0]  v;
    sum = 25'(p.r) * 25'(kr) + 25'(p.g) * 25'(kg) + 25'(p.b) * 25'(kb);
    v   = sum[24:16];
    return v[8] ? 8'd255 : v[7:0];
  endfunction

endpackage

@@ rtl/pixel_effect_chain_unit.sv @@
// pixel_effect_chain_unit: ARGB pixel through a chain of configured color effect slots.
// Depends on pec_pkg for effect codes, coefficients and arithmetic helpers.
//
//   channel   direction  handshake                 payload
//   pixel in  input      in_valid_i / in_stall_o   blue_in_i green_in_i red_in_i alpha_in_i
//   pixel out output     out_valid_o / out_stall_i blue_out_o green_out_o red_out_o alpha_out_o
//   config    input      cfg_we_i                  cfg_idx_i cfg_wdata_i
//
// one pixel per cycle sustained while the output is not stalled; the pipeline is an input
// register, then per slot a luma/operand stage and a multiply/clamp stage.
// each stage loads when it is empty or the next stage moves, so bubbles fill up
// while the output is stalled. reset empties the pipeline and sets every slot to
// no effect with neutral factor.
module pixel_effect_chain_unit #(
  parameter int EFFECT_SLOTS = pec_pkg::DefaultSlots
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pec_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pec_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   blue_in_i,
  input  logic [7:0]                   green_in_i,
  input  logic [7:0]                   red_in_i,
  input  logic [7:0]                   alpha_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   blue_out_o,
  output logic [7:0]                   green_out_o,
  output logic [7:0]                   red_out_o,
  output logic [7:0]                   alpha_out_o
);
  import pec_pkg::*;

  localparam int NStg = 1 + 2 * EFFECT_SLOTS;

  // slot registers, all kept even when the chain is shorter
  logic [EffectW-1:0]        effect_q [MaxSlots];
  logic signed [FactorW-1:0] factor_q [MaxSlots];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxSlots; i++) begin
        effect_q[i] <= FxNone;
        factor_q[i] <= FactorReset;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0]) begin
        factor_q[cfg_idx_i[CfgIdxW-1:1]] <= cfg_wdata_i[FactorW-1:0];
      end else begin
        effect_q[cfg_idx_i[CfgIdxW-1:1]] <= cfg_wdata_i[EffectW-1:0];
      end
    end
  end

  // pipeline control
  logic [NStg-1:0] vld_q;
  logic [NStg:0]   rdy;
  logic [NStg-1:0] vin;
  logic [NStg-1:0] ld;

  always_comb begin
    rdy[NStg] = !out_stall_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vin[0] = in_valid_i;
    for (int k = 1; k < NStg; k++) begin
      vin[k] = vld_q[k-1];
    end
    ld = vin & rdy[NStg-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vin[k];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  // payload
  rgb_t       pix_q   [NStg];
  logic [7:0] alpha_q [NStg];

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      pix_q[0]   <= '{b: blue_in_i, g: green_in_i, r: red_in_i};
      alpha_q[0] <= alpha_in_i;
    end
    for (int k = 1; k < NStg; k++) begin
      if (ld[k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  for (genvar s = 0; s < EFFECT_SLOTS; s++) begin : gen_slot
    localparam int SA = 1 + 2 * s;
    localparam int SB = 2 + 2 * s;

    // operand stage
    rgb_t              p_a;
    logic [7:0]        ch_a   [3];
    logic [7:0]        lum_a;
    rgb_t              res_d;
    logic signed [9:0] dif_d  [3];
    rgb_t              res_q;
    logic signed [9:0] dif_q  [3];
    logic [7:0]        lum_q;

    assign p_a   = pix_q[SA-1];
    assign ch_a  = '{p_a.b, p_a.g, p_a.r};
    assign lum_a = luma_of(p_a);

    always_comb begin
      res_d = p_a;
      case (effect_q[s])
        FxGray:   res_d = '{b: lum_a, g: lum_a, r: lum_a};
        FxSepia: begin
          res_d.r = sepia_ch(p_a, SepRr, SepRg, SepRb);
          res_d.g = sepia_ch(p_a, SepGr, SepGg, SepGb);
          res_d.b = sepia_ch(p_a, SepBr, SepBg, SepBb);
        end
        FxInvert: res_d = ~p_a;
        default:  res_d = p_a;
      endcase
      for (int c = 0; c < 3; c++) begin
        case (effect_q[s])
          FxContrast: dif_d[c] = $signed({2'b00, ch_a[c]}) - 10'sd128;
          FxSat:      dif_d[c] = $signed({2'b00, ch_a[c]}) - $signed({2'b00, lum_a});
          default:    dif_d[c] = 10'sd0;
        endcase
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[SA]) begin
        pix_q[SA] <= p_a;
        res_q     <= res_d;
        dif_q     <= dif_d;
        lum_q     <= lum_a;
      end
    end

    // multiply and clamp stage
    rgb_t               p_b;
    logic [7:0]         ch_b   [3];
    logic [7:0]         out_b  [3];
    logic signed [16:0] fm256;
    acc_t               off;
    acc_t               base;
    logic signed [25:0] prod   [3];
    acc_t               sum    [3];

    assign p_b  = pix_q[SB-1];
    assign ch_b = '{p_b.b, p_b.g, p_b.r};

    always_comb begin
      fm256 = 17'(factor_q[s]) - 17'sd256;
      // halve toward zero
      if (fm256 < 0) begin
        off = AccW'((fm256 + 17'sd1) >>> 1);
      end else begin
        off = AccW'(fm256 >>> 1);
      end
      base = (effect_q[s] == FxSat) ? acc_t'({lum_q, 8'd0}) : ContrastBias;
      for (int c = 0; c < 3; c++) begin
        prod[c] = 26'(dif_q[c]) * 26'(factor_q[s]);
        sum[c]  = AccW'(prod[c]) + base;
        case (effect_q[s]) inside
          FxBright:          out_b[c] = clamp8(acc_t'(ch_b[c]) + off);
          FxContrast, FxSat: out_b[c] = clamp8(div256_tz(sum[c]));
          default:           out_b[c] = 8'd0;
        endcase
      end
    end

    always_ff @(posedge clk_i) begin
      if (ld[SB]) begin
        case (effect_q[s]) inside
          FxBright, FxContrast, FxSat:
            pix_q[SB] <= '{b: out_b[0], g: out_b[1], r: out_b[2]};
          default:
            pix_q[SB] <= res_q;
        endcase
      end
    end
  end

  assign out_valid_o = vld_q[NStg-1];
  assign blue_out_o  = pix_q[NStg-1].b;
  assign green_out_o = pix_q[NStg-1].g;
  assign red_out_o   = pix_q[NStg-1].r;
  assign alpha_out_o = alpha_q[NStg-1];

endmodule

@@ verif/tb.sv @@
// tb: self-checking bench for pixel_effect_chain_unit, four effect slots on ARGB words.
// Depends on pec_pkg and the RTL only; a tracker class predicts each word and checks results.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pec_pkg::*;

  localparam int ChainSlots   = DefaultSlots;
  localparam int Latency      = 1 + 2 * ChainSlots;
  localparam int DrainCycles  = Latency + 2;
  localparam int CycleLimit   = 200_000;
  localparam int PhaseItems   = 167;
  localparam int MaxReports   = 10;
  localparam int RegsPerSlot  = 2;
  localparam int EffectRegOfs = 0;
  localparam int FactorRegOfs = 1;
  localparam int PadW         = CfgDataW - EffectW;

  // code outside the effect list, passes the pixel unchanged
  localparam logic [EffectW-1:0] FxUnused = 3'd7;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } argb_t;

  // directed chains, slot 3 first in each concatenation
  localparam logic [4*EffectW-1:0] DirCodes [5] = '{
    {FxUnused, FxBright, FxBright, FxBright},
    {FxNone, FxBright, FxInvert, FxBright},
    {FxNone, FxContrast, FxContrast, FxContrast},
    {FxContrast, FxGray, FxSat, FxSat},
    {FxSat, FxSepia, FxInvert, FxSepia}
  };
  localparam logic [4*FactorW-1:0] DirFactors [5] = '{
    {16'sd999, 16'sd400, 16'sd100, 16'sd255},
    {16'sh8000, 16'sh7fff, -16'sd1, 16'sh8000},
    {-16'sd77, 16'sh7fff, -16'sd256, 16'sd384},
    {16'sh8000, 16'sd777, 16'sd512, -16'sd300},
    {16'sd0, 16'sd4096, 16'sd50, 16'sd0}
  };
  localparam logic [31:0] DirPixels [4] = '{
    32'h0000_0000, 32'hffff_ffff, 32'ha580_7f01, 32'h5a10_e0c8
  };

  class effect_chain_tracker;
    logic [EffectW-1:0]        slot_effect [MaxSlots];
    logic signed [FactorW-1:0] slot_factor [MaxSlots];
    argb_t                     pending [$];
    int                        errors;

    function new();
      for (int s = 0; s < MaxSlots; s++) begin
        slot_effect[s] = FxNone;
        slot_factor[s] = FactorReset;
      end
      errors = 0;
    endfunction

    function void set_reg(int idx, logic [CfgDataW-1:0] data);
      int slot;
      slot = idx / RegsPerSlot;
      if (idx % RegsPerSlot == FactorRegOfs) begin
        slot_factor[slot] = data;
      end else begin
        slot_effect[slot] = data[EffectW-1:0];
      end
    endfunction

    function int clip8(int v);
      return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    function argb_t chain_pixel(argb_t p);
      int    ch [3];
      int    r, g, b, lum, off, f;
      argb_t res;
      ch[0] = p.b;
      ch[1] = p.g;
      ch[2] = p.r;
      for (int s = 0; s < ChainSlots; s++) begin
        r   = ch[2];
        g   = ch[1];
        b   = ch[0];
        f   = slot_factor[s];
        lum = (int'(LumaKr) * r + int'(LumaKg) * g + int'(LumaKb) * b) >> 8;
        case (slot_effect[s])
          FxBright: begin
            off = (f - 256) / 2;
            for (int k = 0; k < 3; k++) ch[k] = clip8(ch[k] + off);
          end
          FxContrast: begin
            for (int k = 0; k < 3; k++) ch[k] = clip8(((ch[k] - 128) * f + 32768) / 256);
          end
          FxSat: begin
            for (int k = 0; k < 3; k++) ch[k] = clip8((lum * 256 + (ch[k] - lum) * f) / 256);
          end
          FxGray: begin
            for (int k = 0; k < 3; k++) ch[k] = clip8(lum);
          end
          FxSepia: begin
            ch[2] = clip8((int'(SepRr) * r + int'(SepRg) * g + int'(SepRb) * b) >> 16);
            ch[1] = clip8((int'(SepGr) * r + int'(SepGg) * g + int'(SepGb) * b) >> 16);
            ch[0] = clip8((int'(SepBr) * r + int'(SepBg) * g + int'(SepBb) * b) >> 16);
          end
          FxInvert: begin
            for (int k = 0; k < 3; k++) ch[k] = 255 - ch[k];
          end
          default: ;
        endcase
      end
      res.a = p.a;
      res.r = 8'(ch[2]);
      res.g = 8'(ch[1]);
      res.b = 8'(ch[0]);
      return res;
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= MaxReports) $display("%0t ns mismatch: %s", $time, msg);
    endfunction

    function void note_pixel(argb_t p);
      pending = {pending, chain_pixel(p)};
    endfunction

    function void check_pixel(argb_t got);
      argb_t want;
      if (pending.size() == 0) begin
        note_error($sformatf("word %h with nothing outstanding", got));
        return;
      end
      want = pending.pop_front();
      if (got.b !== want.b) note_error($sformatf("blue exp %h got %h", want.b, got.b));
      if (got.g !== want.g) note_error($sformatf("green exp %h got %h", want.g, got.g));
      if (got.r !== want.r) note_error($sformatf("red exp %h got %h", want.r, got.r));
      if (got.a !== want.a) note_error($sformatf("alpha exp %h got %h", want.a, got.a));
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          blue_in_i   = '0;
  logic [7:0]          green_in_i  = '0;
  logic [7:0]          red_in_i    = '0;
  logic [7:0]          alpha_in_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          blue_out_o;
  logic [7:0]          green_out_o;
  logic [7:0]          red_out_o;
  logic [7:0]          alpha_out_o;

  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  effect_chain_tracker tracker       = new();

  pixel_effect_chain_unit #(
    .EFFECT_SLOTS(ChainSlots)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .blue_in_i   (blue_in_i),
    .green_in_i  (green_in_i),
    .red_in_i    (red_in_i),
    .alpha_in_i  (alpha_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .blue_out_o  (blue_out_o),
    .green_out_o (green_out_o),
    .red_out_o   (red_out_o),
    .alpha_out_o (alpha_out_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      tracker.check_pixel(argb_t'({alpha_out_o, red_out_o, green_out_o, blue_out_o}));
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("pixel_effect_chain_unit regression: fail");
    $finish;
  end

  task automatic send_pixel(input argb_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    blue_in_i  <= p.b;
    green_in_i <= p.g;
    red_in_i   <= p.r;
    alpha_in_i <= p.a;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_pixel(p);
  endtask

  // hold the input off until every outstanding word is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic program_chain(input logic [4*EffectW-1:0] codes,
                               input logic [4*FactorW-1:0] factors);
    logic [CfgDataW-1:0] data;
    for (int s = 0; s < MaxSlots; s++) begin
      // junk above the code bits must be dropped
      data        = {PadW'($urandom), codes[s*EffectW +: EffectW]};
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgIdxW'(s * RegsPerSlot + EffectRegOfs);
      cfg_wdata_i <= data;
      tracker.set_reg(s * RegsPerSlot + EffectRegOfs, data);
      @(posedge clk_i);
      data        = factors[s*FactorW +: FactorW];
      cfg_idx_i   <= CfgIdxW'(s * RegsPerSlot + FactorRegOfs);
      cfg_wdata_i <= data;
      tracker.set_reg(s * RegsPerSlot + FactorRegOfs, data);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [FactorW-1:0] random_factor();
    logic [FactorW-1:0] f;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: f = 16'h8000;
          1: f = 16'h7fff;
          2: f = '0;
          default: f = FactorReset;
        endcase
      end
      1: f = 16'($urandom);
      2: f = 16'(FactorReset + $urandom_range(0, 64) - 32);
      default: f = 16'($urandom_range(0, 768) - 256);
    endcase
    return f;
  endfunction

  function automatic argb_t random_pixel();
    argb_t p;
    p = argb_t'($urandom);
    // push channels to the rails now and then
    if ($urandom_range(0, 3) == 0) p.r = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 3) == 0) p.g = $urandom_range(0, 1) ? 8'hff : 8'h00;
    if ($urandom_range(0, 3) == 0) p.b = $urandom_range(0, 1) ? 8'hff : 8'h00;
    return p;
  endfunction

  initial begin
    int                     sent;
    int                     seg;
    logic [4*EffectW-1:0]   codes;
    logic [4*FactorW-1:0]   factors;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 28;
    recv_idle_pct = 87;

    // reset chain first, then the directed chains
    foreach (DirPixels[i]) send_pixel(argb_t'(DirPixels[i]));
    foreach (DirCodes[d]) begin
      wait_drained();
      program_chain(DirCodes[d], DirFactors[d]);
      foreach (DirPixels[i]) send_pixel(argb_t'(DirPixels[i]));
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 28;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 28;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        wait_drained();
        for (int s = 0; s < MaxSlots; s++) begin
          codes[s*EffectW +: EffectW]   = EffectW'($urandom_range(0, 7));
          factors[s*FactorW +: FactorW] = random_factor();
        end
        program_chain(codes, factors);
        seg = $urandom_range(10, 40);
        for (int n = 0; n < seg && sent < PhaseItems; n++) begin
          if ($urandom_range(0, 49) == 0) wait_drained();
          send_pixel(random_pixel());
          sent++;
        end
      end
    end

    in_valid_i <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("pixel_effect_chain_unit regression: pass");
    end else begin
      $display("pixel_effect_chain_unit regression: fail");
    end
    $finish;
  end

endmodule
